[hw/rtl/hfe_pkg.sv]
// Shared constants, types and the FCS-16 byte update for the HDLC frame encoder.
`default_nettype none
package hfe_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] FCS_POLY  = 16'h8408;
  localparam logic [15:0] FCS_START = 16'hFFFF;

  localparam int unsigned CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ADDR_0  = 3'd0;
  localparam cfg_idx_t REG_ADDR_1  = 3'd1;
  localparam cfg_idx_t REG_ADDR_2  = 3'd2;
  localparam cfg_idx_t REG_ADDR_3  = 3'd3;
  localparam cfg_idx_t REG_CONTROL = 3'd4;
  localparam cfg_idx_t REG_STATION = 3'd5;

  localparam logic [7:0] CONTROL_RESET = 8'h03;

  typedef logic [2:0] slot_t;

  localparam slot_t SLOT_OPEN   = 3'd0;
  localparam slot_t SLOT_ADDR   = 3'd1;
  localparam slot_t SLOT_CTRL   = 3'd2;
  localparam slot_t SLOT_STN    = 3'd3;
  localparam slot_t SLOT_DATA   = 3'd4;
  localparam slot_t SLOT_FCS_LO = 3'd5;
  localparam slot_t SLOT_FCS_HI = 3'd6;
  localparam slot_t SLOT_CLOSE  = 3'd7;

  typedef struct packed {
    logic [3:0][7:0] address;
    logic [7:0]      control;
    logic [7:0]      station;
  } regs_t;

  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] f;
    f = fcs ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (f[0]) begin
        f = (f >> 1) ^ FCS_POLY;
      end else begin
        f = f >> 1;
      end
    end
    return f;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/hfe_in_if.sv]
// Input channel: payload byte with end-of-frame mark.
`default_nettype none
interface hfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       end_of_frame;

  modport source (output valid, output payload_byte, output end_of_frame, input ready);
  modport sink   (input valid, input payload_byte, input end_of_frame, output ready);
endinterface
`default_nettype wire

[hw/rtl/hfe_out_if.sv]
// Result channel: one line byte with end-of-run mark.
`default_nettype none
interface hfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       last_of_run;

  modport source (output valid, output line_byte, output last_of_run, input ready);
  modport sink   (input valid, input line_byte, input last_of_run, output ready);
endinterface
`default_nettype wire

[hw/rtl/hfe_cfg_if.sv]
// Configuration write channel: register index and write data.
`default_nettype none
interface hfe_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [hfe_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/hfe_cfg_regs.sv]
// Configuration register bank: address rotation, control and station bytes.
`default_nettype none
module hfe_cfg_regs (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hfe_cfg_if.sink     cfg_ch,
  output hfe_pkg::regs_t regs
);

  hfe_pkg::regs_t regs_r;

  assign cfg_ch.ready = 1'b1;
  assign regs         = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.address <= '0;
      regs_r.control <= hfe_pkg::CONTROL_RESET;
      regs_r.station <= 8'h00;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        hfe_pkg::REG_ADDR_0:  regs_r.address[0] <= cfg_ch.data;
        hfe_pkg::REG_ADDR_1:  regs_r.address[1] <= cfg_ch.data;
        hfe_pkg::REG_ADDR_2:  regs_r.address[2] <= cfg_ch.data;
        hfe_pkg::REG_ADDR_3:  regs_r.address[3] <= cfg_ch.data;
        hfe_pkg::REG_CONTROL: regs_r.control    <= cfg_ch.data;
        hfe_pkg::REG_STATION: regs_r.station    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/hdlc_frame_encoder_fcs16_core.sv]
// Top level: HDLC-like async frame encoder with byte stuffing and FCS-16.
//
//  channel | dir | payload                       | transfer when
//  in_ch   | in  | payload_byte[7:0], end_of_frame | valid && ready
//  out_ch  | out | line_byte[7:0], last_of_run     | valid && ready
//  cfg_ch  | in  | index[2:0], data[7:0]          | valid && ready (ready tied high)
//
// One line byte per cycle leaves the emitter while out_ch is not stalled; an input item
// causes 1 to 14 line bytes, each passing through the single output byte slot.
// The next item is taken in the cycle its predecessor emits its final byte.
// FCS is folded one byte at a time as header and payload bytes are emitted.
// Synchronous active-low reset clears frame state and restarts the address rotation at address 0.
// out_ch stalls hold the output register and freeze the emitter.
`default_nettype none
module hdlc_frame_encoder_fcs16_core (
  input wire logic clk,
  input wire logic rst_n,
  hfe_in_if.sink   in_ch,
  hfe_out_if.source out_ch,
  hfe_cfg_if.sink  cfg_ch
);

  hfe_pkg::regs_t regs;

  hfe_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  logic           in_frame_r;
  logic [1:0]     addr_slot_r;
  logic           item_v_r;
  logic [7:0]     item_byte_r;
  logic           item_eof_r;
  logic [7:0]     item_addr_r;
  hfe_pkg::slot_t slot_r;
  logic           phase_r;
  logic [15:0]    fcs_r;
  logic           out_v_r;
  logic [7:0]     out_byte_r;
  logic           out_last_r;

  logic [7:0]     cur_byte;
  logic           stuffable;
  logic           is_data;
  logic           need_esc;
  logic [7:0]     line_nxt;
  logic           at_end_slot;
  logic           byte_last;
  logic           adv;
  logic           step;
  logic           accept;
  logic [1:0]     addr_slot_nxt;
  logic [15:0]    fcs_base;

  always_comb begin
    case (slot_r)
      hfe_pkg::SLOT_OPEN:   cur_byte = hfe_pkg::FLAG_BYTE;
      hfe_pkg::SLOT_ADDR:   cur_byte = item_addr_r;
      hfe_pkg::SLOT_CTRL:   cur_byte = regs.control;
      hfe_pkg::SLOT_STN:    cur_byte = regs.station;
      hfe_pkg::SLOT_DATA:   cur_byte = item_byte_r;
      hfe_pkg::SLOT_FCS_LO: cur_byte = fcs_r[7:0];
      hfe_pkg::SLOT_FCS_HI: cur_byte = fcs_r[15:8];
      default:              cur_byte = hfe_pkg::FLAG_BYTE;
    endcase
  end

  assign stuffable   = (slot_r != hfe_pkg::SLOT_OPEN) && (slot_r != hfe_pkg::SLOT_CLOSE);
  assign is_data     = (slot_r == hfe_pkg::SLOT_ADDR) || (slot_r == hfe_pkg::SLOT_CTRL) ||
                       (slot_r == hfe_pkg::SLOT_STN)  || (slot_r == hfe_pkg::SLOT_DATA);
  assign need_esc    = stuffable &&
                       ((cur_byte == hfe_pkg::FLAG_BYTE) || (cur_byte == hfe_pkg::ESC_BYTE));
  assign line_nxt    = phase_r  ? (cur_byte ^ hfe_pkg::ESC_XOR) :
                       need_esc ? hfe_pkg::ESC_BYTE : cur_byte;
  assign at_end_slot = slot_r == (item_eof_r ? hfe_pkg::SLOT_CLOSE : hfe_pkg::SLOT_DATA);
  assign byte_last   = at_end_slot && (phase_r || !need_esc);

  assign adv    = !out_v_r || out_ch.ready;
  assign step   = adv && item_v_r;
  assign in_ch.ready = !item_v_r || (step && byte_last);
  assign accept = in_ch.valid && in_ch.ready;

  assign addr_slot_nxt = addr_slot_r + 2'd1;
  assign fcs_base      = (slot_r == hfe_pkg::SLOT_ADDR) ? hfe_pkg::FCS_START : fcs_r;

  // frame tracking and item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      addr_slot_r <= 2'd3;
      item_v_r    <= 1'b0;
      slot_r      <= hfe_pkg::SLOT_OPEN;
      phase_r     <= 1'b0;
    end else begin
      if (accept) begin
        in_frame_r  <= !in_ch.end_of_frame;
        item_v_r    <= 1'b1;
        phase_r     <= 1'b0;
        if (in_frame_r) begin
          slot_r <= hfe_pkg::SLOT_DATA;
        end else begin
          slot_r      <= hfe_pkg::SLOT_OPEN;
          addr_slot_r <= addr_slot_nxt;
        end
      end else if (step) begin
        if (need_esc && !phase_r) begin
          phase_r <= 1'b1;
        end else begin
          phase_r <= 1'b0;
          if (at_end_slot) begin
            item_v_r <= 1'b0;
          end else begin
            slot_r <= slot_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_byte_r <= in_ch.payload_byte;
      item_eof_r  <= in_ch.end_of_frame;
      item_addr_r <= regs.address[addr_slot_nxt];
    end
    if (step && is_data && !phase_r) begin
      fcs_r <= hfe_pkg::fcs_update(fcs_base, cur_byte);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= item_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r <= line_nxt;
      out_last_r <= byte_last;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.line_byte   = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the HDLC frame encoder with byte stuffing and FCS-16.
`timescale 1ns / 100ps

module tb;
  import hfe_pkg::*;

  localparam int MAX_LINES    = 14;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 100;
  localparam int PHASE_ITEMS  = 25;
  localparam int N_ROWS       = 20;

  localparam cfg_idx_t REG_SPARE_6 = 3'd6;
  localparam cfg_idx_t REG_SPARE_7 = 3'd7;

  typedef enum logic [2:0] {
    AIM_NONE, AIM_LO_FLAG, AIM_LO_ESC, AIM_HI_FLAG, AIM_HI_ESC
  } fcs_aim_e;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       last_of_run;
  } line_t;

  // hand-written line bytes for a row, first byte in b[0]
  typedef struct packed {
    logic [3:0]      n;
    logic [0:7][7:0] b;
  } typed_t;

  typedef struct packed {
    logic       ph;
    logic [7:0] pl;
    logic       eof;
    fcs_aim_e   aim;
    typed_t     t;
  } row_t;

  typedef struct packed {
    logic            framing;
    logic [15:0]     fcs;
    logic [1:0]      slot;
    logic [5:0][7:0] regs;
  } enc_state_t;

  localparam typed_t NO_TYPED = '0;

  logic clk;
  logic rst_n;

  hfe_in_if  in_ch ();
  hfe_out_if out_ch ();
  hfe_cfg_if cfg_ch ();

  hdlc_frame_encoder_fcs16_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  enc_state_t  enc;
  line_t       line_q [$];
  typed_t      typed_q [$];
  row_t        dir_rows [N_ROWS];
  int          burst_left = 0;
  int          n_errors = 0;
  int          n_bytes = 0;
  int          n_frames = 0;
  int          n_lines = 0;
  int          n_escapes = 0;
  int          n_settings = 0;
  int          cycles = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  logic [3:0]  stall_pos = '0;
  int          stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] fcs_fold(logic [15:0] f, logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb = f[0] ^ b[k];
      f  = f >> 1;
      if (fb) begin
        f = f ^ FCS_POLY;
      end
    end
    return f;
  endfunction

  // Line bytes caused by one payload byte; advances the encoder state.
  function automatic void encode_step(inout enc_state_t st, input logic [7:0] pl,
                                      input logic eof, output line_t res [MAX_LINES],
                                      output int n);
    logic [7:0] seq [8];
    logic       raw [8];
    int         m;
    m = 0;
    n = 0;
    res = '{default: '0};
    if (!st.framing) begin
      st.framing = 1'b1;
      st.fcs     = FCS_START;
      st.slot    = st.slot + 2'd1;
      seq[0] = FLAG_BYTE;
      raw[0] = 1'b1;
      seq[1] = st.regs[st.slot];
      seq[2] = st.regs[REG_CONTROL];
      seq[3] = st.regs[REG_STATION];
      raw[1] = 1'b0;
      raw[2] = 1'b0;
      raw[3] = 1'b0;
      m = 4;
    end
    seq[m] = pl;
    raw[m] = 1'b0;
    m++;
    for (int i = 0; i < m; i++) begin
      if (!raw[i]) begin
        st.fcs = fcs_fold(st.fcs, seq[i]);
      end
    end
    if (eof) begin
      seq[m]     = st.fcs[7:0];
      seq[m + 1] = st.fcs[15:8];
      seq[m + 2] = FLAG_BYTE;
      raw[m]     = 1'b0;
      raw[m + 1] = 1'b0;
      raw[m + 2] = 1'b1;
      m += 3;
      st.framing = 1'b0;
      st.fcs     = FCS_START;
    end
    for (int i = 0; i < m; i++) begin
      if (!raw[i] && (seq[i] == FLAG_BYTE || seq[i] == ESC_BYTE)) begin
        res[n] = '{ESC_BYTE, 1'b0};
        n++;
        res[n] = '{seq[i] ^ ESC_XOR, 1'b0};
      end else begin
        res[n] = '{seq[i], 1'b0};
      end
      n++;
    end
    res[n - 1].last_of_run = 1'b1;
  endfunction

  function automatic void note_error(string msg);
    if (n_errors < 10) begin
      $display("%s", msg);
    end
    n_errors++;
  endfunction

  // receiver stall pattern, re-drawn each time its random hold count runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pat  <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_pos    <= stall_pos + 4'd1;
    out_ch.ready <= stall_pat[stall_pos];
  end

  always @(posedge clk) begin : check_lines
    line_t  res [MAX_LINES];
    int     n;
    typed_t t;
    line_t  want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index <= REG_STATION) begin
        enc.regs[cfg_ch.index] = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        encode_step(enc, in_ch.payload_byte, in_ch.end_of_frame, res, n);
        t = typed_q.pop_front();
        if (t.n != 0) begin
          for (int i = 0; i < int'(t.n); i++) begin
            line_q.push_back('{t.b[i], i == int'(t.n) - 1});
          end
        end else begin
          for (int i = 0; i < n; i++) begin
            line_q.push_back(res[i]);
          end
        end
        n_bytes++;
        if (in_ch.end_of_frame) begin
          n_frames++;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (out_ch.line_byte == ESC_BYTE) begin
          n_escapes++;
        end
        if (line_q.size() == 0) begin
          note_error($sformatf("unexpected line byte %02h last %0b at transfer %0d",
                               out_ch.line_byte, out_ch.last_of_run, n_lines));
        end else begin
          want = line_q.pop_front();
          if (want.line_byte !== out_ch.line_byte ||
              want.last_of_run !== out_ch.last_of_run) begin
            note_error($sformatf("transfer %0d: expected %02h last %0b, got %02h last %0b",
                                 n_lines, want.line_byte, want.last_of_run,
                                 out_ch.line_byte, out_ch.last_of_run));
          end
        end
        n_lines++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d line bytes outstanding.", cycles, line_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic hold_off(input int c);
    in_ch.valid        <= 1'b0;
    in_ch.payload_byte <= 8'($urandom);
    in_ch.end_of_frame <= 1'($urandom);
    repeat (c) @(posedge clk);
  endtask

  task automatic send_payload(input logic [7:0] pl, input logic eof, input typed_t t);
    if (burst_left == 0) begin
      hold_off(($urandom_range(0, 4) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    typed_q.push_back(t);
    in_ch.valid        <= 1'b1;
    in_ch.payload_byte <= pl;
    in_ch.end_of_frame <= eof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic load_regs(input logic [5:0][7:0] v, input logic spares);
    for (int i = 0; i <= int'(REG_STATION); i++) begin
      cfg_write(cfg_idx_t'(i), v[i]);
    end
    // out-of-range indexes last so an aliased write would show up
    if (spares) begin
      cfg_write(REG_SPARE_6, 8'($urandom));
      cfg_write(REG_SPARE_7, 8'($urandom));
    end
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_drained();
    hold_off(1);
    while (line_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [5:0][7:0] v;
    enc_state_t      st;
    line_t           res [MAX_LINES];
    int              n;
    logic [7:0]      pl;
    logic [7:0]      target;
    logic [7:0]      fcs_b;
    logic            cur_ph;
    int              rp;
    int              n_rand;
    int              phase_cnt;
    int              len;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.payload_byte = '0;
    in_ch.end_of_frame = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    out_ch.ready       = 1'b0;

    enc.framing = 1'b0;
    enc.fcs     = FCS_START;
    enc.slot    = 2'd3;
    enc.regs    = '0;
    enc.regs[REG_CONTROL] = CONTROL_RESET;

    dir_rows = '{
      // reset registers: header is 00 03 00
      '{1'b0, 8'h00, 1'b0, AIM_NONE, '{4'd5, 64'h7E00030000000000}},
      '{1'b0, 8'h7E, 1'b0, AIM_NONE, '{4'd2, 64'h7D5E000000000000}},
      '{1'b0, 8'h7D, 1'b0, AIM_NONE, '{4'd2, 64'h7D5D000000000000}},
      '{1'b0, 8'hFF, 1'b1, AIM_NONE, NO_TYPED},
      '{1'b0, 8'h7E, 1'b1, AIM_NONE, NO_TYPED},
      '{1'b0, 8'h55, 1'b0, AIM_NONE, '{4'd5, 64'h7E00030055000000}},
      '{1'b0, 8'hAA, 1'b1, AIM_NONE, NO_TYPED},
      // flag and escape values in the header, distinct addresses
      '{1'b1, 8'h00, 1'b0, AIM_NONE, '{4'd7, 64'h7E007D5D7D5E0000}},
      '{1'b1, 8'h7D, 1'b1, AIM_NONE, NO_TYPED},
      '{1'b1, 8'h00, 1'b1, AIM_LO_FLAG, NO_TYPED},
      '{1'b1, 8'h00, 1'b1, AIM_LO_ESC, NO_TYPED},
      '{1'b1, 8'h00, 1'b1, AIM_HI_FLAG, NO_TYPED},
      '{1'b1, 8'h00, 1'b1, AIM_HI_ESC, NO_TYPED},
      '{1'b1, 8'h7E, 1'b1, AIM_NONE, NO_TYPED},
      '{1'b1, 8'h01, 1'b0, AIM_NONE, NO_TYPED},
      '{1'b1, 8'h80, 1'b0, AIM_NONE, NO_TYPED},
      '{1'b1, 8'hFE, 1'b0, AIM_NONE, NO_TYPED},
      '{1'b1, 8'h7F, 1'b1, AIM_NONE, NO_TYPED},
      '{1'b1, 8'hFF, 1'b0, AIM_NONE, NO_TYPED},
      '{1'b1, 8'h00, 1'b1, AIM_NONE, NO_TYPED}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    n_settings = 1;
    cur_ph     = 1'b0;
    for (int r = 0; r < N_ROWS; r++) begin
      if (dir_rows[r].ph != cur_ph) begin
        wait_drained();
        v[REG_ADDR_0]  = FLAG_BYTE;
        v[REG_ADDR_1]  = ESC_BYTE;
        v[REG_ADDR_2]  = 8'hFF;
        v[REG_ADDR_3]  = 8'h00;
        v[REG_CONTROL] = ESC_BYTE;
        v[REG_STATION] = FLAG_BYTE;
        load_regs(v, 1'b1);
        cur_ph = dir_rows[r].ph;
      end
      pl = dir_rows[r].pl;
      if (dir_rows[r].aim != AIM_NONE) begin
        // settle the prediction, then pick a byte that puts a flag or escape into the FCS
        hold_off(1);
        target = (dir_rows[r].aim == AIM_LO_FLAG || dir_rows[r].aim == AIM_HI_FLAG) ?
                 FLAG_BYTE : ESC_BYTE;
        for (int c = 0; c < 256; c++) begin
          st = enc;
          encode_step(st, 8'(c), 1'b0, res, n);
          fcs_b = (dir_rows[r].aim == AIM_HI_FLAG || dir_rows[r].aim == AIM_HI_ESC) ?
                  st.fcs[15:8] : st.fcs[7:0];
          if (fcs_b == target) begin
            pl = 8'(c);
          end
        end
      end
      send_payload(pl, dir_rows[r].eof, dir_rows[r].t);
    end

    rp     = 0;
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      wait_drained();
      for (int i = 0; i <= int'(REG_STATION); i++) begin
        if (rp == 0) begin
          v[i] = 8'hFF;
        end else if (rp == 1) begin
          v[i] = 8'h00;
        end else if ($urandom_range(0, 2) == 0) begin
          v[i] = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
        end else begin
          v[i] = 8'($urandom);
        end
      end
      load_regs(v, rp >= 2 && $urandom_range(0, 1) == 1);
      phase_cnt = 0;
      while (phase_cnt < PHASE_ITEMS) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 7))
            0: pl = FLAG_BYTE;
            1: pl = ESC_BYTE;
            2: pl = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: pl = 8'($urandom);
          endcase
          send_payload(pl, k == len - 1, NO_TYPED);
          phase_cnt++;
          n_rand++;
        end
      end
      rp++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (line_q.size() != 0) begin
      note_error($sformatf("%0d expected line bytes never arrived", line_q.size()));
    end

    $display("Encoded %0d payload bytes in %0d frames under %0d register settings.",
             n_bytes, n_frames, n_settings);
    $display("Checked %0d line bytes (%0d escapes), %0d mismatches.",
             n_lines, n_escapes, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
